// ----- rtl/trpt_pkg.sv -----
// Package for the trimmed region point test: word types, opcodes, vertex flags
// and default sizes.
// No dependencies; trpt_cross_unit and the top level depend on it.
package trpt_pkg;

    localparam int FIELD_W          = 16;
    localparam int FLAG_W           = 4;
    localparam int MAX_VERTICES_DEF = 256;
    localparam int COORD_BITS_DEF   = 16;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } trpt_op_t;

    typedef struct packed {
        logic [1:0]                opcode;
        logic signed [FIELD_W-1:0] coord_u;
        logic signed [FIELD_W-1:0] coord_v;
        logic                      ends_curve;
        logic                      curve_closed;
        logic                      ends_loop;
        logic                      loop_is_outer;
    } trpt_req_t;

    typedef struct packed {
        logic inside_res;
        logic status;
    } trpt_rsp_t;

    typedef struct packed {
        logic outer;
        logic end_loop;
        logic closed;
        logic end_curve;
    } trpt_flags_t;

    typedef struct packed {
        logic done;
        logic hit;
    } trpt_cross_t;

endpackage

// ----- rtl/trpt_vertex_mem.sv -----
// Vertex table: one write port and one read port with a registered read word.
// Depends on nothing but its parameters.
module trpt_vertex_mem #(
    parameter int DEPTH  = 256,
    parameter int DATA_W = 36
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/trpt_cross_unit.sv -----
// Shared ray crossing unit: decides whether the +u ray from a point crosses a
// segment, using one multiplier for both products. Depends on trpt_pkg.
module trpt_cross_unit #(
    parameter int CW = trpt_pkg::FIELD_W
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic signed [CW-1:0]  a_u,
    input  logic signed [CW-1:0]  a_v,
    input  logic signed [CW-1:0]  b_u,
    input  logic signed [CW-1:0]  b_v,
    input  logic signed [CW-1:0]  p_u,
    input  logic signed [CW-1:0]  p_v,
    output trpt_pkg::trpt_cross_t res
);

    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;

    typedef enum logic [3:0] {
        U_IDLE  = 4'b0001,
        U_MUL_L = 4'b0010,
        U_MUL_R = 4'b0100,
        U_CMP   = 4'b1000
    } phase_t;

    phase_t phase_reg, phase_next;

    logic signed [DW-1:0] dv_w, dpv_w, dbu_w, dpu_w;
    logic signed [DW-1:0] dv_reg, dpv_reg, dbu_reg, dpu_reg;
    logic signed [DW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] lhs_reg, rhs_reg;
    logic                 straddle_w, left_w;
    logic                 hit_ok_reg, dv_pos_reg;

    assign dv_w  = DW'(b_v) - DW'(a_v);
    assign dpv_w = DW'(p_v) - DW'(a_v);
    assign dbu_w = DW'(b_u) - DW'(a_u);
    assign dpu_w = DW'(p_u) - DW'(a_u);

    assign straddle_w = (a_v <= p_v && b_v > p_v) || (b_v <= p_v && a_v > p_v);
    assign left_w     = (a_u < p_u) && (b_u < p_u);

    assign mul_a = (phase_reg == U_MUL_L) ? dpv_reg : dpu_reg;
    assign mul_b = (phase_reg == U_MUL_L) ? dbu_reg : dv_reg;
    assign prod  = mul_a * mul_b;

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            U_IDLE:
            begin
                if (start)
                begin
                    phase_next = U_MUL_L;
                end
            end
            U_MUL_L: phase_next = U_MUL_R;
            U_MUL_R: phase_next = U_CMP;
            U_CMP:   phase_next = U_IDLE;
            default: phase_next = U_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= U_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (phase_reg == U_IDLE && start)
        begin
            dv_reg     <= dv_w;
            dpv_reg    <= dpv_w;
            dbu_reg    <= dbu_w;
            dpu_reg    <= dpu_w;
            hit_ok_reg <= straddle_w && !left_w;
            dv_pos_reg <= b_v > a_v;
        end
        if (phase_reg == U_MUL_L)
        begin
            lhs_reg <= prod;
        end
        if (phase_reg == U_MUL_R)
        begin
            rhs_reg <= prod;
        end
    end

    assign res.done = (phase_reg == U_CMP);
    assign res.hit  = hit_ok_reg && (dv_pos_reg ? (lhs_reg >= rhs_reg) : (lhs_reg <= rhs_reg));

endmodule

// ----- rtl/trimmed_region_point_test_unit.sv -----
// Top level of the trimmed region point test: command sequencer, vertex table
// and shared crossing unit. Depends on trpt_pkg, trpt_vertex_mem, trpt_cross_unit.
//
//   Channel  Signals                   Word        Direction
//   req      req_valid/req_ready/req   trpt_req_t  command in
//   rsp      rsp_valid/rsp_ready/rsp   trpt_rsp_t  one result word per command
//
// Clear, append and unused opcodes go from acceptance through ST_FINISH to the result.
// A query steps, per stored vertex, through ST_READ and ST_LOAD; a vertex that
// starts a curve goes on to ST_POST, others wait for the crossing unit on a
// segment in ST_WAIT_MAIN and, for a closing segment, again in ST_WAIT_CLOSE.
// Reset clears the vertex count; the table contents are not cleared.
// A new command is taken while the previous result waits in the output register.
module trimmed_region_point_test_unit #(
    parameter int MAX_VERTICES = trpt_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = trpt_pkg::COORD_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  trpt_pkg::trpt_req_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output trpt_pkg::trpt_rsp_t rsp
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int NW = AW + 1;
    localparam int CW = (COORD_BITS < trpt_pkg::FIELD_W) ? COORD_BITS : trpt_pkg::FIELD_W;
    localparam int FW = trpt_pkg::FLAG_W;
    localparam int VW = 2 * CW + FW;
    localparam logic [NW-1:0] MAX_CNT = NW'(MAX_VERTICES);

    typedef enum logic [7:0] {
        ST_IDLE       = 8'b0000_0001,
        ST_READ       = 8'b0000_0010,
        ST_LOAD       = 8'b0000_0100,
        ST_WAIT_MAIN  = 8'b0000_1000,
        ST_CLOSE      = 8'b0001_0000,
        ST_WAIT_CLOSE = 8'b0010_0000,
        ST_POST       = 8'b0100_0000,
        ST_FINISH     = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [NW-1:0] count_reg, i_reg, start_idx_reg;
    logic          status_reg, query_reg;
    logic          odd_reg, any_loop_reg, in_outer_reg, in_hole_reg;
    logic          out_valid_reg;
    trpt_pkg::trpt_rsp_t out_data_reg;

    logic signed [CW-1:0] pu_reg, pv_reg;
    logic signed [CW-1:0] cur_u_reg, cur_v_reg, prev_u_reg, prev_v_reg;
    logic signed [CW-1:0] start_u_reg, start_v_reg;
    trpt_pkg::trpt_flags_t cur_f_reg;

    logic                  accept, full, slot_free, closing, first_of_curve;
    logic signed [CW-1:0]  in_u, in_v, rd_u, rd_v;
    trpt_pkg::trpt_flags_t in_f, rd_f;
    logic                  wr_en;
    logic [VW-1:0]         wr_data, rd_data;

    logic                  cu_start;
    logic signed [CW-1:0]  cu_a_u, cu_a_v, cu_b_u, cu_b_v;
    trpt_pkg::trpt_cross_t cu_res;
    trpt_pkg::trpt_rsp_t   result;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign full      = (count_reg == MAX_CNT);
    assign slot_free = !out_valid_reg || rsp_ready;

    assign in_u = req.coord_u[CW-1:0];
    assign in_v = req.coord_v[CW-1:0];
    assign in_f.outer     = req.loop_is_outer;
    assign in_f.end_loop  = req.ends_loop;
    assign in_f.closed    = req.curve_closed;
    assign in_f.end_curve = req.ends_curve;

    assign wr_en   = accept && (req.opcode == trpt_pkg::OP_APPEND) && !full;
    assign wr_data = {in_u, in_v, in_f};

    assign rd_u = rd_data[VW-1 -: CW];
    assign rd_v = rd_data[FW+CW-1 -: CW];
    assign rd_f = rd_data[FW-1:0];

    trpt_vertex_mem #(
        .DEPTH  (MAX_VERTICES),
        .DATA_W (VW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (state_reg == ST_READ),
        .rd_addr (i_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    assign first_of_curve = (i_reg == start_idx_reg);
    assign closing = (cur_f_reg.end_curve || cur_f_reg.end_loop) && cur_f_reg.closed;

    assign cu_start = ((state_reg == ST_LOAD) && !first_of_curve)
                    || ((state_reg == ST_CLOSE) && closing);
    assign cu_a_u = (state_reg == ST_CLOSE) ? cur_u_reg : prev_u_reg;
    assign cu_a_v = (state_reg == ST_CLOSE) ? cur_v_reg : prev_v_reg;
    assign cu_b_u = (state_reg == ST_CLOSE) ? start_u_reg : rd_u;
    assign cu_b_v = (state_reg == ST_CLOSE) ? start_v_reg : rd_v;

    trpt_cross_unit #(
        .CW (CW)
    ) u_cross (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cu_start),
        .a_u   (cu_a_u),
        .a_v   (cu_a_v),
        .b_u   (cu_b_u),
        .b_v   (cu_b_v),
        .p_u   (pu_reg),
        .p_v   (pv_reg),
        .res   (cu_res)
    );

    assign result.inside_res = query_reg && (!any_loop_reg || (in_outer_reg && !in_hole_reg));
    assign result.status     = status_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.opcode == trpt_pkg::OP_QUERY && count_reg != '0)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_READ: state_next = ST_LOAD;
            ST_LOAD: state_next = first_of_curve ? ST_POST : ST_WAIT_MAIN;
            ST_WAIT_MAIN:
            begin
                if (cu_res.done)
                begin
                    state_next = ST_CLOSE;
                end
            end
            ST_CLOSE: state_next = closing ? ST_WAIT_CLOSE : ST_POST;
            ST_WAIT_CLOSE:
            begin
                if (cu_res.done)
                begin
                    state_next = ST_POST;
                end
            end
            ST_POST:
            begin
                state_next = ((i_reg + NW'(1)) == count_reg) ? ST_FINISH : ST_READ;
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            i_reg         <= '0;
            start_idx_reg <= '0;
            status_reg    <= 1'b0;
            query_reg     <= 1'b0;
            odd_reg       <= 1'b0;
            any_loop_reg  <= 1'b0;
            in_outer_reg  <= 1'b0;
            in_hole_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                unique case (req.opcode)
                    trpt_pkg::OP_CLEAR:
                    begin
                        count_reg <= '0;
                    end
                    trpt_pkg::OP_APPEND:
                    begin
                        if (!full)
                        begin
                            count_reg <= count_reg + NW'(1);
                        end
                    end
                    trpt_pkg::OP_QUERY, trpt_pkg::OP_NONE:
                    begin
                        count_reg <= count_reg;
                    end
                endcase
                status_reg    <= (req.opcode == trpt_pkg::OP_APPEND) && full;
                query_reg     <= (req.opcode == trpt_pkg::OP_QUERY);
                i_reg         <= '0;
                start_idx_reg <= '0;
                odd_reg       <= 1'b0;
                any_loop_reg  <= 1'b0;
                in_outer_reg  <= 1'b0;
                in_hole_reg   <= 1'b0;
            end
            if ((state_reg == ST_WAIT_MAIN || state_reg == ST_WAIT_CLOSE) && cu_res.done)
            begin
                odd_reg <= odd_reg ^ cu_res.hit;
            end
            if (state_reg == ST_POST)
            begin
                i_reg <= i_reg + NW'(1);
                if (cur_f_reg.end_curve || cur_f_reg.end_loop)
                begin
                    start_idx_reg <= i_reg + NW'(1);
                end
                if (cur_f_reg.end_loop)
                begin
                    any_loop_reg <= 1'b1;
                    odd_reg      <= 1'b0;
                    if (odd_reg && cur_f_reg.outer)
                    begin
                        in_outer_reg <= 1'b1;
                    end
                    if (odd_reg && !cur_f_reg.outer)
                    begin
                        in_hole_reg <= 1'b1;
                    end
                end
            end
            if (state_reg == ST_FINISH && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pu_reg <= in_u;
            pv_reg <= in_v;
        end
        if (state_reg == ST_LOAD)
        begin
            cur_u_reg <= rd_u;
            cur_v_reg <= rd_v;
            cur_f_reg <= rd_f;
            if (first_of_curve)
            begin
                start_u_reg <= rd_u;
                start_v_reg <= rd_v;
            end
        end
        if (state_reg == ST_POST)
        begin
            prev_u_reg <= cur_u_reg;
            prev_v_reg <= cur_v_reg;
        end
        if (state_reg == ST_FINISH && slot_free)
        begin
            out_data_reg <= result;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;

    // The vertex count never passes the table depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("vertex count exceeds table depth");

    // The crossing unit only finishes while the sequencer waits for it.
    a_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        cu_res.done |-> (state_reg == ST_WAIT_MAIN || state_reg == ST_WAIT_CLOSE))
        else $error("crossing result arrived outside a wait state");

    // A query only reads entries that have been written.
    a_read_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (i_reg < count_reg))
        else $error("query reads beyond the stored vertices");

    // An append to a table with room adds exactly one vertex.
    a_append_fill: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> (count_reg == ($past(count_reg) + NW'(1))))
        else $error("append did not advance the vertex count");

    // A finished command with a free output register shows its result next cycle.
    a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && !out_valid_reg) |=> out_valid_reg)
        else $error("finished result was not presented");

endmodule
